// ===== sv/wildcard_capture_matcher_top_assert.svh =====
// Assertion macros for the wildcard capture matcher top level.
// Both macros expect signals named clk and rst in the enclosing scope.
`ifndef WILDCARD_CAPTURE_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_CAPTURE_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication.
`define WCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wcm_pkg.sv =====
// ----------------------------------------------------------------------------
// wcm_pkg
// Constants, types and helpers shared by the wildcard capture matcher files.
// ----------------------------------------------------------------------------
package wcm_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int CAPTURE_MAX   = 32;
  localparam int POSITION_BITS = 16;

  localparam int CHAR_W    = 8;
  localparam int END_W     = 16;
  localparam int REG_W     = 64;
  localparam int LEN_W     = 5;
  localparam int OFS_W     = 16;
  localparam int REG_IDX_W = 2;

  localparam int PAT_CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int PAT_IDX_W = $clog2(PATTERN_MAX);
  localparam int CNT_W     = $clog2(CAPTURE_MAX + 1);
  localparam int CAP_IDX_W = (CAPTURE_MAX > 1) ? $clog2(CAPTURE_MAX) : 1;
  localparam int RAM_DEPTH = 2 * (2 ** CAP_IDX_W);
  localparam int RAM_ADDR_W = CAP_IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [CHAR_W-1:0] SKIP_MARK = 8'h2A;
  localparam logic [CHAR_W-1:0] CAPT_MARK = 8'h40;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_START    = 2'd3
  } reg_idx_t;

  // One finished run handed from the matcher to the result side.
  typedef struct packed {
    logic             found;
    logic             empty;
    logic             trunc;
    logic [END_W-1:0] endp;
    logic [CNT_W-1:0] count;
    logic             bank;
  } run_desc_t;

  // Capture bank freed by the result side.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [PAT_CNT_W-1:0] pat_len(input logic [LEN_W-1:0] n);
    logic [PAT_CNT_W-1:0] r;
    if (n == '0) begin
      r = PAT_CNT_W'(1);
    end else if (int'(n) > PATTERN_MAX) begin
      r = PAT_CNT_W'(PATTERN_MAX);
    end else begin
      r = PAT_CNT_W'(n);
    end
    return r;
  endfunction

endpackage

// ===== sv/wildcard_capture_matcher_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_capture_matcher_top
// Wildcard pattern matcher with capture over a character stream.
//
// Channel   Direction  Handshake        Words
// input     in         push / full      text_char, first_char, last_char
// result    out        pop / empty      capture_char .. run_last
// config    in         wr_en            wr_index, wr_data
//
// A character is held while the stepper in wcm_front runs its pattern steps
// (markers, skip/capture tests, one restart); a character of a text that
// already gave its result is taken without any pattern step.
// A result word is loaded once its RAM read is back and the next read
// starts after the pop, so a new word is not read before the last is popped.
// Reset is synchronous; the capture RAM is not cleared and needs no sweep.
// full holds while a character is in work, the run queue is full, or the
// capture bank in use still holds a run not yet delivered.
// ----------------------------------------------------------------------------
module wildcard_capture_matcher_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [wcm_pkg::CHAR_W-1:0]       text_char,
  input  logic                             first_char,
  input  logic                             last_char,
  output logic                             empty,
  input  logic                             pop,
  output logic [wcm_pkg::CHAR_W-1:0]       capture_char,
  output logic                             match_found,
  output logic                             capture_empty,
  output logic                             capture_truncated,
  output logic [wcm_pkg::END_W-1:0]        end_position,
  output logic                             run_last,
  input  logic                             wr_en,
  input  logic [wcm_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [wcm_pkg::REG_W-1:0]        wr_data
);

  import wcm_pkg::*;

  `include "wildcard_capture_matcher_top_assert.svh"

  logic                  enq;
  run_desc_t             enq_desc;
  logic                  deq;
  run_desc_t             head;
  logic                  q_full;
  logic                  q_empty;
  bank_rel_t             rel;
  logic                  cap_we;
  logic [RAM_ADDR_W-1:0] cap_waddr;
  logic [CHAR_W-1:0]     cap_wdata;
  logic [RAM_ADDR_W-1:0] cap_raddr;
  logic [CHAR_W-1:0]     cap_rdata;

  wcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .text_char (text_char),
    .first_char(first_char),
    .last_char (last_char),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_full    (q_full),
    .rel       (rel),
    .enq       (enq),
    .enq_desc  (enq_desc),
    .cap_we    (cap_we),
    .cap_waddr (cap_waddr),
    .cap_wdata (cap_wdata)
  );

  wcm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_desc(enq_desc),
    .deq     (deq),
    .head    (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  wcm_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(RAM_DEPTH)
  ) u_cap_ram (
    .clk  (clk),
    .we   (cap_we),
    .waddr(cap_waddr),
    .wdata(cap_wdata),
    .raddr(cap_raddr),
    .rdata(cap_rdata)
  );

  wcm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .q_empty          (q_empty),
    .deq              (deq),
    .rel              (rel),
    .cap_raddr        (cap_raddr),
    .cap_rdata        (cap_rdata),
    .empty            (empty),
    .pop              (pop),
    .capture_char     (capture_char),
    .match_found      (match_found),
    .capture_empty    (capture_empty),
    .capture_truncated(capture_truncated),
    .end_position     (end_position),
    .run_last         (run_last)
  );

  `WCM_ASSERT_SAME(a_full_on_queue_full, q_full, full, "queue full but input open")
  `WCM_ASSERT_SAME(a_enq_has_room, enq, !q_full, "run posted into a full queue")
  `WCM_ASSERT_SAME(a_deq_has_run, deq, !q_empty, "run taken from an empty queue")
  `WCM_ASSERT_NEXT(a_enq_visible, enq, !q_empty, "posted run not visible")

endmodule

// ===== sv/wcm_ram.sv =====
// ----------------------------------------------------------------------------
// wcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/wcm_front.sv =====
// ----------------------------------------------------------------------------
// wcm_front
// Configuration registers, text position and the pattern stepper. Takes one
// character, runs pattern steps one per cycle, writes captured characters and
// posts a run descriptor when a match or the end of the text is reached.
// ----------------------------------------------------------------------------
module wcm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [wcm_pkg::CHAR_W-1:0]           text_char,
  input  logic                                 first_char,
  input  logic                                 last_char,
  input  logic                                 wr_en,
  input  logic [wcm_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [wcm_pkg::REG_W-1:0]            wr_data,
  input  logic                                 q_full,
  input  wcm_pkg::bank_rel_t                   rel,
  output logic                                 enq,
  output wcm_pkg::run_desc_t                   enq_desc,
  output logic                                 cap_we,
  output logic [wcm_pkg::RAM_ADDR_W-1:0]       cap_waddr,
  output logic [wcm_pkg::CHAR_W-1:0]           cap_wdata
);

  import wcm_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_STEP = 2'b10
  } front_state_t;

  front_state_t state;

  logic [REG_W-1:0]  pat_low;
  logic [REG_W-1:0]  pat_high;
  logic [LEN_W-1:0]  pat_length;
  logic [OFS_W-1:0]  start_offset;

  logic [CHAR_W-1:0]        ch;
  logic                     lastc;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] text_position;
  logic                     matched_done;
  logic                     run;
  logic                     consumed;
  logic [PAT_CNT_W-1:0]     idx;
  logic                     skipping;
  logic                     capturing;
  logic                     overflowed;
  logic [CNT_W-1:0]         count;
  logic                     bank;
  logic [1:0]               bank_busy;
  logic [1:0]               bank_busy_next;

  logic [2*REG_W-1:0]       pattern;
  logic [PAT_CNT_W-1:0]     len;
  logic [CHAR_W-1:0]        p;
  logic                     is_skip;
  logic                     is_capt;
  logic                     hit;
  logic                     step_go;
  logic                     finish;
  logic                     matched;
  logic                     accept;
  logic                     cap_room;
  logic [POSITION_BITS-1:0] pos_cur;
  logic                     done_eff;
  logic [POSITION_BITS-1:0] endp_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low      <= '0;
      pat_high     <= '0;
      pat_length   <= LEN_W'(1);
      start_offset <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_PAT_LOW:  pat_low      <= wr_data;
        REG_PAT_HIGH: pat_high     <= wr_data;
        REG_PAT_LEN:  pat_length   <= wr_data[LEN_W-1:0];
        REG_START:    start_offset <= wr_data[OFS_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    pattern  = {pat_high, pat_low};
    len      = pat_len(pat_length);
    p        = pattern[idx[PAT_IDX_W-1:0]*CHAR_W +: CHAR_W];
    is_skip  = (p == SKIP_MARK);
    is_capt  = (p == CAPT_MARK);
    hit      = (ch == p);
    step_go  = (state == F_STEP) && run && !consumed && (idx < len);
    finish   = (state == F_STEP) && !step_go;
    matched  = run && (idx >= len);
    cap_room = (count < CNT_W'(CAPTURE_MAX));
    accept   = push && !full;
    pos_cur  = first_char ? '0 : text_position;
    done_eff = first_char ? 1'b0 : matched_done;
    endp_full = (consumed && (pos != POS_MAX)) ? pos + POSITION_BITS'(1) : pos;
  end

  // Free a bank once its run is delivered, claim the current one on a match.
  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.valid) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (finish && matched) begin
      bank_busy_next[bank] = 1'b1;
    end
  end

  assign full = (state != F_IDLE) || q_full || bank_busy[bank];

  assign cap_we    = step_go && !is_skip && !is_capt && !skipping && capturing &&
                     !hit && cap_room;
  assign cap_waddr = {bank, count[CAP_IDX_W-1:0]};
  assign cap_wdata = ch;

  assign enq = finish && (matched || lastc);
  always_comb begin
    enq_desc.found = matched;
    enq_desc.empty = matched && (count == '0);
    enq_desc.trunc = matched && overflowed;
    enq_desc.endp  = matched ? END_W'(endp_full) : '0;
    enq_desc.count = matched ? count : '0;
    enq_desc.bank  = bank;
  end

  // Character payload.
  always_ff @(posedge clk) begin
    if ((state == F_IDLE) && accept) begin
      ch    <= text_char;
      lastc <= last_char;
      pos   <= pos_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      text_position <= '0;
      matched_done  <= 1'b0;
      run           <= 1'b0;
      consumed      <= 1'b0;
      idx           <= '0;
      skipping      <= 1'b0;
      capturing     <= 1'b0;
      overflowed    <= 1'b0;
      count         <= '0;
      bank          <= 1'b0;
      bank_busy     <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (first_char) begin
              idx        <= '0;
              skipping   <= 1'b0;
              capturing  <= 1'b0;
              count      <= '0;
              overflowed <= 1'b0;
            end
            text_position <= (pos_cur != POS_MAX) ? pos_cur + POSITION_BITS'(1) : pos_cur;
            matched_done  <= done_eff;
            consumed      <= 1'b0;
            run           <= (pos_cur >= POSITION_BITS'(start_offset));
            // A text that already gave its result ignores the character.
            if (!done_eff) begin
              state <= F_STEP;
            end
          end
        end
        F_STEP: begin
          if (step_go) begin
            priority if (is_skip) begin
              skipping <= 1'b1;
              idx      <= idx + PAT_CNT_W'(1);
            end else if (is_capt) begin
              capturing <= 1'b1;
              idx       <= idx + PAT_CNT_W'(1);
            end else if (skipping) begin
              if (hit) skipping <= 1'b0;
              else     consumed <= 1'b1;
            end else if (capturing) begin
              if (hit) begin
                capturing <= 1'b0;
              end else begin
                if (cap_room) count <= count + CNT_W'(1);
                else          overflowed <= 1'b1;
                consumed <= 1'b1;
              end
            end else if (hit) begin
              idx      <= idx + PAT_CNT_W'(1);
              consumed <= 1'b1;
            end else if (idx == '0) begin
              consumed <= 1'b1;
            end else begin
              // Literal mismatch: restart the pattern on this character.
              idx        <= '0;
              skipping   <= 1'b0;
              capturing  <= 1'b0;
              count      <= '0;
              overflowed <= 1'b0;
            end
          end else begin
            state <= F_IDLE;
            if (matched) begin
              matched_done <= 1'b1;
              bank         <= ~bank;
            end else if (lastc) begin
              matched_done <= 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/wcm_queue.sv =====
// ----------------------------------------------------------------------------
// wcm_queue
// Short queue of run descriptors between the matcher and the result side.
// ----------------------------------------------------------------------------
module wcm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               enq,
  input  wcm_pkg::run_desc_t enq_desc,
  input  logic               deq,
  output wcm_pkg::run_desc_t head,
  output logic               q_full,
  output logic               q_empty
);

  import wcm_pkg::*;

  run_desc_t           entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  fill;

  assign head    = entries[rd_ptr];
  assign q_full  = (fill == Q_CNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= enq_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      priority if (enq && !deq) fill <= fill + Q_CNT_W'(1);
      else if (deq && !enq)     fill <= fill - Q_CNT_W'(1);
    end
  end

endmodule

// ===== sv/wcm_back.sv =====
// ----------------------------------------------------------------------------
// wcm_back
// Result side: walks the head run descriptor, reads captured characters from
// the capture RAM and holds one result word in an output register.
// ----------------------------------------------------------------------------
module wcm_back (
  input  logic                               clk,
  input  logic                               rst,
  input  wcm_pkg::run_desc_t                 head,
  input  logic                               q_empty,
  output logic                               deq,
  output wcm_pkg::bank_rel_t                 rel,
  output logic [wcm_pkg::RAM_ADDR_W-1:0]     cap_raddr,
  input  logic [wcm_pkg::CHAR_W-1:0]         cap_rdata,
  output logic                               empty,
  input  logic                               pop,
  output logic [wcm_pkg::CHAR_W-1:0]         capture_char,
  output logic                               match_found,
  output logic                               capture_empty,
  output logic                               capture_truncated,
  output logic [wcm_pkg::END_W-1:0]          end_position,
  output logic                               run_last
);

  import wcm_pkg::*;

  logic             out_valid;
  logic             rd_pend;
  logic [CNT_W-1:0] k;
  logic             issue;
  logic             last_item;

  assign issue     = !out_valid && !rd_pend && !q_empty;
  assign last_item = (head.count == '0) || ((k + CNT_W'(1)) == head.count);
  assign deq       = rd_pend && last_item;
  assign cap_raddr = {head.bank, k[CAP_IDX_W-1:0]};
  assign empty     = !out_valid;

  always_comb begin
    rel.valid = deq && head.found;
    rel.bank  = head.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      k         <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (rd_pend) begin
        rd_pend   <= 1'b0;
        out_valid <= 1'b1;
        k         <= last_item ? '0 : k + CNT_W'(1);
      end else if (issue) begin
        rd_pend <= 1'b1;
      end
    end
  end

  // Load the result word once the RAM read data is back.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      capture_char      <= (head.found && !head.empty) ? cap_rdata : '0;
      match_found       <= head.found;
      capture_empty     <= head.empty;
      capture_truncated <= head.trunc;
      end_position      <= head.endp;
      run_last          <= last_item;
    end
  end

endmodule
